>>> design/wfps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfps_pkg
// Shared types, constants and helpers for the wall following pid steering block.
// ----------------------------------------------------------------------------
package wfps_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam int unsigned GAIN_W   = 16;
	localparam int unsigned SPEED_W  = 8;
	localparam int unsigned DIST_W   = 11;
	localparam int unsigned ERR_W    = 14;
	localparam int unsigned DERR_W   = 15;
	localparam int unsigned SUM_W    = 24;
	localparam int unsigned CORR_W   = 42;
	localparam int unsigned SCALED_W = 43;
	localparam int unsigned FRAC_W   = 9;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [DIST_W-1:0]      WALL_LIMIT_MM = DIST_W'(80);
	localparam logic [SPEED_W-1:0]     SPEED_MIN     = SPEED_W'(60);
	localparam logic [SPEED_W-1:0]     SPEED_MAX     = SPEED_W'(225);
	localparam logic signed [ERR_W-1:0] SMALL_ERR    = 14'sd6;

	localparam logic [GAIN_W-1:0]  GAIN_P_RST  = GAIN_W'(179);
	localparam logic [GAIN_W-1:0]  GAIN_I_RST  = GAIN_W'(0);
	localparam logic [GAIN_W-1:0]  GAIN_D_RST  = GAIN_W'(5120);
	localparam logic [SPEED_W-1:0] BASE_L_RST  = SPEED_W'(100);
	localparam logic [SPEED_W-1:0] BASE_R_RST  = SPEED_W'(120);
	localparam logic [DIST_W-1:0]  TARGET_L_RST = DIST_W'(75);
	localparam logic [DIST_W-1:0]  TARGET_R_RST = DIST_W'(97);

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_LEFT  = 2'd1,
		MODE_RIGHT = 2'd2,
		MODE_BOTH  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P   = 3'd0,
		REG_GAIN_I   = 3'd1,
		REG_GAIN_D   = 3'd2,
		REG_BASE_L   = 3'd3,
		REG_BASE_R   = 3'd4,
		REG_TARGET_L = 3'd5,
		REG_TARGET_R = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  gain_p;
		logic [GAIN_W-1:0]  gain_i;
		logic [GAIN_W-1:0]  gain_d;
		logic [SPEED_W-1:0] base_speed_left;
		logic [SPEED_W-1:0] base_speed_right;
		logic [DIST_W-1:0]  target_left_mm;
		logic [DIST_W-1:0]  target_right_mm;
	} wfps_cfg_t;

	typedef struct packed {
		mode_t                     mode;
		logic                      near_zero;
		logic signed [ERR_W-1:0]   err;
		logic signed [DERR_W-1:0]  derr;
		logic signed [SUM_W-1:0]   sum;
	} wfps_item_t;

	// scaled duty in 1/512 units to a clamped 8 bit duty, truncating toward zero
	function automatic logic [SPEED_W-1:0] clamp_speed(input logic signed [SCALED_W-1:0] s);
		logic [SCALED_W-FRAC_W-1:0] whole;
		logic [SPEED_W-1:0]         res;
		whole = s[SCALED_W-1:FRAC_W];
		if (s[SCALED_W-1]) begin
			res = SPEED_MIN;
		end else if (whole < (SCALED_W-FRAC_W)'(SPEED_MIN)) begin
			res = SPEED_MIN;
		end else if (whole > (SCALED_W-FRAC_W)'(SPEED_MAX)) begin
			res = SPEED_MAX;
		end else begin
			res = whole[SPEED_W-1:0];
		end
		return res;
	endfunction

endpackage

>>> design/wfps_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfps_cfg
// Configuration register file with its write channel.
// ----------------------------------------------------------------------------
module wfps_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wfps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wfps_pkg::CFG_DATA_W-1:0]  cfg_data,
	output wfps_pkg::wfps_cfg_t              cfg
);
	import wfps_pkg::*;

	wfps_cfg_t regs_q;

	assign cfg_ready = 1'b1;
	assign cfg       = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.gain_p           <= GAIN_P_RST;
			regs_q.gain_i           <= GAIN_I_RST;
			regs_q.gain_d           <= GAIN_D_RST;
			regs_q.base_speed_left  <= BASE_L_RST;
			regs_q.base_speed_right <= BASE_R_RST;
			regs_q.target_left_mm   <= TARGET_L_RST;
			regs_q.target_right_mm  <= TARGET_R_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GAIN_P:   regs_q.gain_p           <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:   regs_q.gain_i           <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:   regs_q.gain_d           <= cfg_data[GAIN_W-1:0];
				REG_BASE_L:   regs_q.base_speed_left  <= cfg_data[SPEED_W-1:0];
				REG_BASE_R:   regs_q.base_speed_right <= cfg_data[SPEED_W-1:0];
				REG_TARGET_L: regs_q.target_left_mm   <= cfg_data[DIST_W-1:0];
				REG_TARGET_R: regs_q.target_right_mm  <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

>>> design/wfps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfps_front
// Accepts distance pairs, classifies the wall mode, forms the error and
// keeps the integral and last error state.
// ----------------------------------------------------------------------------
module wfps_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wfps_pkg::wfps_cfg_t           cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [wfps_pkg::DIST_W-1:0]   left_mm,
	input  logic [wfps_pkg::DIST_W-1:0]   right_mm,
	input  logic                          q_ready,
	output logic                          q_push,
	output wfps_pkg::wfps_item_t          q_item
);
	import wfps_pkg::*;

	logic signed [SUM_W-1:0]  error_sum_q;
	logic signed [ERR_W-1:0]  prev_err_q;

	logic                     wall_l, wall_r;
	mode_t                    mode;
	logic signed [ERR_W:0]    diff_l, diff_r, wide_err;
	logic signed [ERR_W-1:0]  err;
	logic signed [SUM_W:0]    sum_wide;
	logic signed [SUM_W-1:0]  sum_sat;
	logic                     near_zero;

	assign in_ready = q_ready;
	assign q_push   = in_valid && q_ready;

	assign wall_l = left_mm < WALL_LIMIT_MM;
	assign wall_r = right_mm < WALL_LIMIT_MM;
	assign mode   = mode_t'({wall_r, wall_l});

	assign diff_l = $signed({4'd0, left_mm}) - $signed({4'd0, cfg.target_left_mm});
	assign diff_r = $signed({4'd0, right_mm}) - $signed({4'd0, cfg.target_right_mm});

	always_comb begin
		unique case (mode)
			MODE_LEFT:  wide_err = diff_l;
			MODE_RIGHT: wide_err = -(diff_r <<< 1);
			MODE_BOTH:  wide_err = (diff_l - diff_r) <<< 1;
			default:    wide_err = '0;
		endcase
	end

	assign err       = wide_err[ERR_W-1:0];
	assign near_zero = (err > -SMALL_ERR) && (err < SMALL_ERR);
	assign sum_wide  = {error_sum_q[SUM_W-1], error_sum_q} + (SUM_W+1)'(err);

	// saturate the integral
	always_comb begin
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[SUM_W-1:0];
		end
	end

	always_comb begin
		q_item.mode      = mode;
		q_item.near_zero = near_zero;
		q_item.err       = err;
		q_item.derr      = {err[ERR_W-1], err} - {prev_err_q[ERR_W-1], prev_err_q};
		q_item.sum       = sum_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q <= '0;
			prev_err_q  <= '0;
		end else if (q_push && (mode != MODE_NONE)) begin
			error_sum_q <= near_zero ? '0 : sum_sat;
			prev_err_q  <= err;
		end
	end

endmodule

>>> design/wfps_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfps_queue
// Small first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module wfps_queue #(
	parameter int unsigned DEPTH = wfps_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  wfps_pkg::wfps_item_t  push_item,
	output logic                  push_ready,
	input  logic                  pop,
	output logic                  pop_valid,
	output wfps_pkg::wfps_item_t  pop_item
);
	import wfps_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	wfps_item_t         entries_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign push_ready = count_q < CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/wfps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfps_back
// PID multiply stage followed by the combine, scale and clamp stage that
// feeds the output register.
// ----------------------------------------------------------------------------
module wfps_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wfps_pkg::wfps_cfg_t           cfg,
	input  logic                          q_valid,
	input  wfps_pkg::wfps_item_t          q_item,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [wfps_pkg::SPEED_W-1:0]  duty_left,
	output logic [wfps_pkg::SPEED_W-1:0]  duty_right,
	output logic [1:0]                    follow_mode
);
	import wfps_pkg::*;

	logic                              valid_s1, valid_s2;
	logic                              s1_ready, s2_ready;
	mode_t                             mode_s1;
	logic                              small_s1;
	logic signed [GAIN_W+ERR_W:0]      prod_p_s1;
	logic signed [GAIN_W+SUM_W:0]      prod_i_s1;
	logic signed [GAIN_W+DERR_W:0]     prod_d_s1;
	logic [SPEED_W-1:0]                duty_left_s2, duty_right_s2;
	mode_t                             mode_s2;

	logic signed [CORR_W-1:0]          corr;
	logic signed [SCALED_W-1:0]        base_l, base_r, scaled_l, scaled_r;
	logic [SPEED_W-1:0]                next_l, next_r;

	assign s2_ready = !valid_s2 || out_ready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign q_pop    = q_valid && s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= q_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// multiply stage
	always_ff @(posedge clk) begin
		if (q_pop) begin
			mode_s1   <= q_item.mode;
			small_s1  <= q_item.near_zero;
			prod_p_s1 <= $signed({1'b0, cfg.gain_p}) * q_item.err;
			prod_i_s1 <= $signed({1'b0, cfg.gain_i}) * q_item.sum;
			prod_d_s1 <= $signed({1'b0, cfg.gain_d}) * q_item.derr;
		end
	end

	assign corr     = CORR_W'(prod_p_s1) + CORR_W'(prod_i_s1) + CORR_W'(prod_d_s1);
	assign base_l   = $signed({{(SCALED_W-SPEED_W-FRAC_W){1'b0}}, cfg.base_speed_left,
		{FRAC_W{1'b0}}});
	assign base_r   = $signed({{(SCALED_W-SPEED_W-FRAC_W){1'b0}}, cfg.base_speed_right,
		{FRAC_W{1'b0}}});
	assign scaled_l = base_l - SCALED_W'(corr);
	assign scaled_r = base_r + SCALED_W'(corr);

	always_comb begin
		if ((mode_s1 == MODE_NONE) || small_s1) begin
			next_l = cfg.base_speed_left;
			next_r = cfg.base_speed_right;
		end else begin
			next_l = clamp_speed(scaled_l);
			next_r = clamp_speed(scaled_r);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (valid_s1 && s2_ready) begin
			duty_left_s2  <= next_l;
			duty_right_s2 <= next_r;
			mode_s2       <= mode_s1;
		end
	end

	assign out_valid   = valid_s2;
	assign duty_left   = duty_left_s2;
	assign duty_right  = duty_right_s2;
	assign follow_mode = mode_s2;

endmodule

>>> design/wall_following_pid_steering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_following_pid_steering
// Wall following PID steering for a differential drive robot.
//
// Input channel in_valid/in_ready carries one left/right wall distance pair
// per request; the output channel out_valid/out_ready returns one duty pair
// and the follow mode for each request, in order. A separate write channel
// cfg_valid/cfg_ready/cfg_index/cfg_data sets gains, base speeds and wall
// targets; it is always ready. The user must write it only while the
// block is idle; the block does not enforce this. Throughput is one
// request per cycle while the receiver does not stall. The front updates
// the integral in the accepting cycle; the request then passes the queue
// of QUEUE_DEPTH entries, the multiply register (three gain multiplies)
// and the output register (combine, scale and clamp) to out_valid. When
// the receiver stalls the back holds its output and the queue fills, after
// which in_ready drops. Reset clears the integral, the last error, the
// queue and the pipeline, and loads the register defaults.
// ----------------------------------------------------------------------------
module wall_following_pid_steering #(
	parameter int unsigned QUEUE_DEPTH = wfps_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wfps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wfps_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [wfps_pkg::DIST_W-1:0]      left_mm,
	input  logic [wfps_pkg::DIST_W-1:0]      right_mm,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [wfps_pkg::SPEED_W-1:0]     duty_left,
	output logic [wfps_pkg::SPEED_W-1:0]     duty_right,
	output logic [1:0]                       follow_mode
);
	import wfps_pkg::*;

	wfps_cfg_t  cfg;
	logic       q_ready, q_push, q_valid, q_pop;
	wfps_item_t push_item, pop_item;

	wfps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wfps_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.left_mm  (left_mm),
		.right_mm (right_mm),
		.q_ready  (q_ready),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	wfps_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (push_item),
		.push_ready (q_ready),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_item   (pop_item)
	);

	wfps_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.q_valid     (q_valid),
		.q_item      (pop_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.duty_left   (duty_left),
		.duty_right  (duty_right),
		.follow_mode (follow_mode)
	);

endmodule

>>> design/wfps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfps_checker
// Port level checks for the steering block, bound to the top level.
// ----------------------------------------------------------------------------
module wfps_checker #(
	parameter int unsigned QUEUE_DEPTH = wfps_pkg::QUEUE_DEPTH_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [wfps_pkg::SPEED_W-1:0]     duty_left,
	input logic [wfps_pkg::SPEED_W-1:0]     duty_right,
	input logic [1:0]                       follow_mode
);
	import wfps_pkg::*;

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 4);

	logic [CNT_W-1:0] pending_q;
	logic             in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// requests accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(duty_left)
			&& $stable(duty_right) && $stable(follow_mode))
		else $error("output changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("result without a pending request");

	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> pending_q >= CNT_W'(QUEUE_DEPTH))
		else $error("input stalled with room to spare");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready && (pending_q <= CNT_W'(QUEUE_DEPTH + 2)))
		else $error("config stalled or too many requests in flight");

endmodule

bind wall_following_pid_steering wfps_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_wfps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_valid   (cfg_valid),
	.cfg_ready   (cfg_ready),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.duty_left   (duty_left),
	.duty_right  (duty_right),
	.follow_mode (follow_mode)
);

>>> bench/wfps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfps_scoreboard
// Watches the config, request and result channels of the steering block,
// keeps its own copy of the registers, integral and last error, predicts
// the duty pair and follow mode for each request and compares every result
// in order. Hands the failure count and the number of outstanding results
// to the testbench top.
// ----------------------------------------------------------------------------
module wfps_scoreboard (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [wfps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wfps_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic [wfps_pkg::DIST_W-1:0]      left_mm,
	input  logic [wfps_pkg::DIST_W-1:0]      right_mm,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic [wfps_pkg::SPEED_W-1:0]     duty_left,
	input  logic [wfps_pkg::SPEED_W-1:0]     duty_right,
	input  logic [1:0]                       follow_mode,
	output int unsigned                      fail_count,
	output int unsigned                      pending
);
	import wfps_pkg::*;

	localparam longint SUM_HI        = 64'sd8388607;
	localparam longint SUM_LO        = -64'sd8388608;
	localparam int     SMALL_HALF_MM = 6;
	localparam int     REPORT_LIMIT  = 10;

	typedef struct packed {
		logic [SPEED_W-1:0] duty_left;
		logic [SPEED_W-1:0] duty_right;
		mode_t              mode;
	} steer_t;

	wfps_cfg_t               regs;
	logic signed [SUM_W-1:0] err_sum;
	logic signed [15:0]      last_err;
	steer_t                  steer_expect_q[$];
	steer_t                  want;
	steer_t                  got;

	initial fail_count = 0;
	initial pending = 0;

	// 1/512 duty units down to a whole duty, truncated toward zero, then clamped
	function automatic logic [SPEED_W-1:0] duty_clamp(input longint scaled);
		longint whole;
		whole = scaled / 512;
		if (whole < longint'(SPEED_MIN)) whole = longint'(SPEED_MIN);
		else if (whole > longint'(SPEED_MAX)) whole = longint'(SPEED_MAX);
		return SPEED_W'(whole);
	endfunction

	function automatic steer_t steer_predict(input logic [DIST_W-1:0] l,
		input logic [DIST_W-1:0] r);
		steer_t res;
		int     el;
		int     er;
		int     e;
		longint acc;
		longint corr;
		longint mag;
		res.duty_left  = regs.base_speed_left;
		res.duty_right = regs.base_speed_right;
		res.mode       = mode_t'({r < WALL_LIMIT_MM, l < WALL_LIMIT_MM});
		if (res.mode != MODE_NONE) begin
			el = int'(l) - int'(regs.target_left_mm);
			er = int'(regs.target_right_mm) - int'(r);
			case (res.mode)
				MODE_LEFT:  e = el;
				MODE_RIGHT: e = 2 * er;
				default:    e = 2 * (el + er);
			endcase
			acc = longint'(err_sum) + e;
			if (acc > SUM_HI) acc = SUM_HI;
			if (acc < SUM_LO) acc = SUM_LO;
			err_sum = SUM_W'(acc);
			corr = longint'(regs.gain_p) * e
				+ longint'(regs.gain_i) * longint'(err_sum)
				+ longint'(regs.gain_d) * (longint'(e) - longint'(last_err));
			mag = (e < 0) ? -longint'(e) : longint'(e);
			if (mag < SMALL_HALF_MM) begin
				err_sum = '0;
			end else begin
				res.duty_left  = duty_clamp(longint'(regs.base_speed_left) * 512 - corr);
				res.duty_right = duty_clamp(longint'(regs.base_speed_right) * 512 + corr);
			end
			last_err = 16'(e);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.gain_p           = GAIN_P_RST;
			regs.gain_i           = GAIN_I_RST;
			regs.gain_d           = GAIN_D_RST;
			regs.base_speed_left  = BASE_L_RST;
			regs.base_speed_right = BASE_R_RST;
			regs.target_left_mm   = TARGET_L_RST;
			regs.target_right_mm  = TARGET_R_RST;
			err_sum  = '0;
			last_err = '0;
			steer_expect_q.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_GAIN_P:   regs.gain_p           = cfg_data;
					REG_GAIN_I:   regs.gain_i           = cfg_data;
					REG_GAIN_D:   regs.gain_d           = cfg_data;
					REG_BASE_L:   regs.base_speed_left  = cfg_data[SPEED_W-1:0];
					REG_BASE_R:   regs.base_speed_right = cfg_data[SPEED_W-1:0];
					REG_TARGET_L: regs.target_left_mm   = cfg_data[DIST_W-1:0];
					REG_TARGET_R: regs.target_right_mm  = cfg_data[DIST_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got.duty_left  = duty_left;
				got.duty_right = duty_right;
				got.mode       = mode_t'(follow_mode);
				if (steer_expect_q.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t: result with no request pending: duty %0d/%0d mode %0d",
							$time, got.duty_left, got.duty_right, got.mode);
				end else begin
					want = steer_expect_q.pop_front();
					if (got.duty_left !== want.duty_left || got.duty_right !== want.duty_right
						|| got.mode !== want.mode) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("%0t: mismatch: expected duty %0d/%0d mode %0d, got %0d/%0d mode %0d",
								$time, want.duty_left, want.duty_right, want.mode,
								got.duty_left, got.duty_right, got.mode);
					end
				end
			end
			if (in_valid && in_ready)
				steer_expect_q.push_back(steer_predict(left_mm, right_mm));
			pending = steer_expect_q.size();
		end
	end

endmodule

>>> bench/wall_following_pid_steering_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_following_pid_steering_tb
// Drives distance pairs into the steering block under random sender gaps and
// receiver stalls, across several register settings including the extremes,
// with one-signed runs that build the integral up one way and back down.
// The scoreboard beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module wall_following_pid_steering_tb;
	import wfps_pkg::*;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [DIST_W-1:0]     left_mm   = '0;
	logic [DIST_W-1:0]     right_mm  = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [SPEED_W-1:0]    duty_left;
	logic [SPEED_W-1:0]    duty_right;
	logic [1:0]            follow_mode;
	int unsigned           fail_count;
	int unsigned           pending;

	logic                  idle_on    = 1'b1;
	logic [DIST_W-1:0]     goal_left  = TARGET_L_RST;
	logic [DIST_W-1:0]     goal_right = TARGET_R_RST;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	wall_following_pid_steering dut (.*);

	wfps_scoreboard u_check (.*);

	initial begin
		#10_000_000;
		$display("FAIL wall_following_pid_steering");
		$finish;
	end

	// receiver stalls at random
	always @(negedge clk) out_ready = !(idle_on && $urandom_range(0, 99) < 37);

	task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// only once all results are back
	task automatic load_setting(input logic [15:0] gp, input logic [15:0] gi,
		input logic [15:0] gd, input logic [15:0] bl, input logic [15:0] br,
		input logic [15:0] tl, input logic [15:0] tr);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		cfg_write(REG_GAIN_P, gp);
		cfg_write(REG_GAIN_I, gi);
		cfg_write(REG_GAIN_D, gd);
		cfg_write(REG_BASE_L, bl);
		cfg_write(REG_BASE_R, br);
		cfg_write(REG_TARGET_L, tl);
		cfg_write(REG_TARGET_R, tr);
		goal_left  = tl[DIST_W-1:0];
		goal_right = tr[DIST_W-1:0];
	endtask

	task automatic rand_setting();
		load_setting(16'($urandom),
			($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64)),
			16'($urandom), 16'($urandom), 16'($urandom),
			{5'($urandom_range(0, 31)), 11'($urandom_range(30, 110))},
			{5'($urandom_range(0, 31)), 11'($urandom_range(30, 110))});
	endtask

	task automatic send_pair(input logic [DIST_W-1:0] l, input logic [DIST_W-1:0] r);
		while (idle_on && $urandom_range(0, 99) < 37) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		left_mm  = l;
		right_mm = r;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// mostly walls present, some near the target for small errors
	function automatic logic [DIST_W-1:0] rand_dist(input logic [DIST_W-1:0] goal);
		int d;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: d = $urandom_range(0, 79);
			5, 6:          d = int'(goal) + int'($urandom_range(0, 8)) - 4;
			7:             d = $urandom_range(80, 2047);
			8:             d = $urandom_range(0, 2047);
			default: begin
				case ($urandom_range(0, 3))
					0:       d = 0;
					1:       d = 79;
					2:       d = 80;
					default: d = 2047;
				endcase
			end
		endcase
		if (d < 0) d = 0;
		if (d > 2047) d = 2047;
		return DIST_W'(d);
	endfunction

	task automatic run_random(input int count);
		repeat (count) send_pair(rand_dist(goal_left), rand_dist(goal_right));
	endtask

	task automatic run_walls(input int count);
		repeat (count) send_pair(DIST_W'($urandom_range(0, 79)), DIST_W'($urandom_range(0, 79)));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// no wall, wall limit edges, small error edges, bit patterns
		send_pair(11'd2047, 11'd2047);
		send_pair(11'd80, 11'd80);
		send_pair(11'd79, 11'd2047);
		send_pair(11'd0, 11'd2047);
		send_pair(11'd2047, 11'd79);
		send_pair(11'd2047, 11'd0);
		send_pair(11'd0, 11'd0);
		send_pair(11'd79, 11'd79);
		send_pair(11'd75, 11'd2047);
		send_pair(11'd70, 11'd2047);
		send_pair(11'd69, 11'd2047);
		send_pair(11'd2047, 11'd95);
		send_pair(11'd2047, 11'd94);
		send_pair(11'd1365, 11'd682);
		send_pair(11'd682, 11'd1365);

		// integral builds up, then a small error clears it
		load_setting(16'd179, 16'd256, 16'd5120, 16'd100, 16'd120, 16'd75, 16'd97);
		send_pair(11'd0, 11'd2047);
		send_pair(11'd0, 11'd2047);
		send_pair(11'd0, 11'd2047);
		send_pair(11'd75, 11'd2047);
		send_pair(11'd0, 11'd2047);
		send_pair(11'd40, 11'd60);

		load_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		run_random(120);
		load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_random(120);
		load_setting(16'd179, 16'd0, 16'd5120, 16'd100, 16'd120, 16'd75, 16'd97);
		run_random(120);

		idle_on = 1'b0;
		rand_setting();
		run_random(300);
		idle_on = 1'b1;

		repeat (4) begin
			rand_setting();
			run_random(120);
		end

		// integral builds one way, then comes back the other way
		load_setting(16'd0, 16'd1, 16'd0, 16'd128, 16'd128, 16'd0, 16'd2047);
		run_walls(60);
		load_setting(16'd0, 16'd1, 16'd0, 16'd128, 16'd128, 16'd2047, 16'd0);
		run_walls(60);

		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("PASS wall_following_pid_steering");
		else
			$display("FAIL wall_following_pid_steering");
		$finish;
	end

endmodule
